// File: hw/rtl/frsq_pkg.sv
`default_nettype none
package frsq_pkg;

	// Input command codes (tuser)
	localparam logic [2:0] CMD_DNA    = 3'd0;
	localparam logic [2:0] CMD_LIT    = 3'd1;
	localparam logic [2:0] CMD_NRUN   = 3'd2;
	localparam logic [2:0] CMD_RAW    = 3'd3;
	localparam logic [2:0] CMD_BSTART = 3'd4;
	localparam logic [2:0] CMD_BEND   = 3'd5;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_LINE_LENGTH = 2'd0;
	localparam logic [1:0] REG_FIRST_BREAK = 2'd1;
	localparam logic [1:0] REG_BLK_LEN     = 2'd2;

	// Letter source of a sequence item
	localparam logic [1:0] LK_DNA  = 2'd0;
	localparam logic [1:0] LK_LIT  = 2'd1;
	localparam logic [1:0] LK_NRUN = 2'd2;

	// Text bytes
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_N  = 8'h4E;

	// Result limit per input beat
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = 6;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_LETTER,
		SQ_RAW,
		SQ_RAW_NL,
		SQ_EOB
	} seq_state_t;

	// Line unit decision
	typedef struct packed {
		logic need_nl;
		logic breaks_off_n;
	} step_res_t;

	// Byte pushed into the output register
	typedef struct packed {
		logic       valid;
		logic [7:0] char_val;
		logic       last;
	} out_push_t;

	// Two-bit base code to letter
	function automatic logic [7:0] base_letter(input logic [1:0] code);
		logic [7:0] ch;
		unique case (code)
			2'd0: ch = 8'h41;
			2'd1: ch = 8'h43;
			2'd2: ch = 8'h54;
			default: ch = 8'h47;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/frsq_step.sv
`default_nettype none
// Line budget unit: decides on a break and computes the next budget
module frsq_step #(
	parameter int LINE_BITS = 16
) (
	input  wire logic [LINE_BITS-1:0] budget,
	input  wire logic                 breaks_off,
	input  wire logic [LINE_BITS-1:0] line_ld,
	input  wire logic                 force_load,
	output frsq_pkg::step_res_t       res,
	output logic      [LINE_BITS-1:0] budget_n
);
	import frsq_pkg::*;

	logic load;

	always_comb begin
		res.need_nl = !breaks_off && (budget == '0);
		load        = force_load || res.need_nl;
		if (load) begin
			// reload the line; a zero length turns breaks off
			budget_n         = line_ld;
			res.breaks_off_n = (line_ld == '0);
		end else begin
			// count one letter off the line
			budget_n         = breaks_off ? budget : budget - LINE_BITS'(1);
			res.breaks_off_n = breaks_off;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/frsq_out.sv
`default_nettype none
// Output register: holds one text beat until the receiver takes it
module frsq_out (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire frsq_pkg::out_push_t push,
	output logic                     slot_free,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,
	output logic                     m_tlast
);
	import frsq_pkg::*;

	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;

	assign slot_free = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = char_q;
	assign m_tlast   = last_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (slot_free && push.valid) begin
			char_q <= push.char_val;
			last_q <= push.last;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/fasta_sequence_reassembler.sv
// Rebuilds FASTA text of one block from decoded sub-stream items.
// Input stream: s_tuser carries the command, s_tdata the data byte and N run
// count, s_tlast marks the last byte of a raw run. Output stream: one text
// byte per beat on m_tdata, m_tlast set on the last byte caused by an input.
// Registers (APB, byte address 4*i): line length, first break offset and
// block length; write them only while the block is idle.
// Throughput: one output byte per cycle while an item is in progress and the
// receiver is ready. An item is taken while the sequencer is idle, which then
// steps once per text byte it produces (a DNA byte 4 to 8, an N run up to
// 2*run, a raw byte 1 or 2) with s_tready low; the line budget unit steps on
// sequence bytes and reloads at a raw run's newline. For items that make
// nothing it stays idle. A first beat passes the state and output registers.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset clears the registers to their defaults, empties the
// output register and sets the line state to breaks off.
`default_nettype none
module fasta_sequence_reassembler #(
	parameter int MAX_RUN    = 16,
	parameter int LINE_BITS  = 16,
	parameter int BLOCK_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [12:8] run_count, zero pad
	input  wire logic [2:0]  s_tuser,   // [2:0] cmd
	input  wire logic        s_tlast,   // raw_last
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_char
	output logic             m_tlast,   // last
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import frsq_pkg::*;

	localparam int RUN_W = $clog2(MAX_RUN + 1) > 5 ? $clog2(MAX_RUN + 1) : 5;
	localparam int REM_W = $clog2(MAX_RUN + 1) > 3 ? $clog2(MAX_RUN + 1) : 3;
	localparam int CMP_W = BLOCK_BITS > 24 ? BLOCK_BITS : 24;

	// Configuration registers
	logic [15:0] line_length_q;
	logic [16:0] first_break_q;
	logic [23:0] blk_len_q;

	// Line and block state
	logic [LINE_BITS-1:0]  line_budget_q;
	logic                  breaks_off_q;
	logic [BLOCK_BITS-1:0] emitted_q;

	// Sequencer
	seq_state_t       state_q, state_n;
	logic [1:0]       kind_q;
	logic [7:0]       data_q;
	logic             raw_last_q;
	logic [REM_W-1:0] rem_q;
	logic [RES_W-1:0] n_q;

	logic                 accept;
	logic                 slot_free;
	logic                 advance;
	logic                 force_load;
	logic                 upd_line;
	logic                 letter_done;
	logic                 cap;
	logic                 at_cap_edge;
	logic [7:0]           letter_char;
	logic [RUN_W-1:0]     run_ext;
	logic [RUN_W-1:0]     run_clamp;
	logic                 bend_nl;
	logic [LINE_BITS-1:0] line_ld;
	logic [LINE_BITS-1:0] budget_n;
	step_res_t            step;
	out_push_t            push;

	// APB port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= 16'd60;
			first_break_q <= 17'h1FFFF;
			blk_len_q     <= 24'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_LINE_LENGTH: line_length_q <= pwdata[15:0];
				REG_FIRST_BREAK: first_break_q <= pwdata[16:0];
				REG_BLK_LEN:     blk_len_q     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LINE_LENGTH: prdata = {16'd0, line_length_q};
			REG_FIRST_BREAK: prdata = {15'd0, first_break_q};
			REG_BLK_LEN:     prdata = {8'd0, blk_len_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Decode helpers
	assign line_ld   = LINE_BITS'(line_length_q);
	assign run_ext   = RUN_W'(s_tdata[12:8]);
	assign run_clamp = (run_ext > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : run_ext;
	assign bend_nl   = CMP_W'(emitted_q) < CMP_W'(blk_len_q);

	assign s_tready = (state_q == SQ_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign cap         = (n_q >= RES_W'(MAX_RESULTS));
	assign at_cap_edge = (n_q == RES_W'(MAX_RESULTS - 1));

	// Current letter
	always_comb begin
		unique case (kind_q)
			LK_DNA:  letter_char = base_letter(data_q[1:0]);
			LK_LIT:  letter_char = data_q;
			default: letter_char = CH_N;
		endcase
	end

	// Shared line budget unit
	frsq_step #(
		.LINE_BITS(LINE_BITS)
	) u_step (
		.budget    (line_budget_q),
		.breaks_off(breaks_off_q),
		.line_ld   (line_ld),
		.force_load(force_load),
		.res       (step),
		.budget_n  (budget_n)
	);

	// Next state and byte selection
	always_comb begin
		state_n       = state_q;
		advance       = 1'b0;
		force_load    = 1'b0;
		upd_line      = 1'b0;
		letter_done   = 1'b0;
		push.char_val = CH_NL;
		push.last     = 1'b1;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						CMD_DNA, CMD_LIT: state_n = SQ_LETTER;
						CMD_NRUN:  state_n = (run_clamp != '0) ? SQ_LETTER : SQ_IDLE;
						CMD_RAW:   state_n = SQ_RAW;
						CMD_BEND:  state_n = bend_nl ? SQ_EOB : SQ_IDLE;
						default:   state_n = SQ_IDLE;
					endcase
				end
			end
			SQ_LETTER: begin
				advance  = slot_free;
				upd_line = advance;
				if (step.need_nl) begin
					// break the line before this letter
					push.char_val = CH_NL;
					push.last     = at_cap_edge;
				end else begin
					push.char_val = letter_char;
					push.last     = (rem_q == REM_W'(1)) || at_cap_edge;
					letter_done   = advance;
					if (advance && rem_q == REM_W'(1))
						state_n = SQ_IDLE;
				end
			end
			SQ_RAW: begin
				advance       = slot_free;
				push.char_val = data_q;
				push.last     = !raw_last_q || at_cap_edge;
				if (advance)
					state_n = raw_last_q ? SQ_RAW_NL : SQ_IDLE;
			end
			SQ_RAW_NL: begin
				advance    = slot_free;
				force_load = 1'b1;
				upd_line   = advance;
				if (advance)
					state_n = SQ_IDLE;
			end
			SQ_EOB: begin
				advance = slot_free;
				if (advance)
					state_n = SQ_IDLE;
			end
			default: state_n = SQ_IDLE;
		endcase
		push.valid = advance && !cap;
	end

	// Output register
	frsq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.slot_free(slot_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SQ_IDLE;
		else
			state_q <= state_n;
	end

	// Item registers: load on accept, step letters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (accept) begin
			n_q <= '0;
		end else if (push.valid) begin
			n_q <= n_q + RES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q     <= s_tdata[7:0];
			raw_last_q <= s_tlast;
			unique case (s_tuser)
				CMD_DNA: begin
					kind_q <= LK_DNA;
					rem_q  <= REM_W'(4);
				end
				CMD_LIT: begin
					kind_q <= LK_LIT;
					rem_q  <= REM_W'(1);
				end
				default: begin
					kind_q <= LK_NRUN;
					rem_q  <= REM_W'(run_clamp);
				end
			endcase
		end else if (letter_done) begin
			data_q <= {2'b00, data_q[7:2]};
			rem_q  <= rem_q - REM_W'(1);
		end
	end

	// Line state and emitted count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_budget_q <= '0;
			breaks_off_q  <= 1'b1;
			emitted_q     <= '0;
		end else begin
			if (accept && s_tuser == CMD_BSTART) begin
				emitted_q <= '0;
				if (first_break_q[16]) begin
					breaks_off_q  <= 1'b1;
					line_budget_q <= '0;
				end else begin
					breaks_off_q  <= 1'b0;
					line_budget_q <= LINE_BITS'(first_break_q[15:0]);
				end
			end else begin
				if (upd_line) begin
					line_budget_q <= budget_n;
					breaks_off_q  <= step.breaks_off_n;
				end
				if (push.valid && emitted_q != '1)
					emitted_q <= emitted_q + BLOCK_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: tb/fasta_sequence_reassembler_tb.sv
`default_nettype none
module fasta_sequence_reassembler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frsq_pkg::*;

	localparam int RUN_CAP      = 16;
	localparam int TEXT_CAP     = 32;
	localparam int DRAIN_PAD    = 8;
	localparam int TAIL_CYCLES  = 20;
	localparam int STALL_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 20;
	localparam int NUM_PHASES   = 6;
	localparam int MAX_REPORTS  = 40;
	localparam logic [2:0]  CMD_SPARE6 = 3'd6;
	localparam logic [2:0]  CMD_SPARE7 = 3'd7;
	// base code k selects byte k, so code 0 is the lowest byte
	localparam logic [31:0] BASE_CHARS = "GTCA";
	localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;
	localparam logic [31:0] NO_BREAK   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} text_beat_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  cmd;
		logic [7:0]  data;
		logic [4:0]  run;
		logic        rlast;
		logic        typed;
		logic [3:0]  n_exp;
		logic [63:0] exp_txt;
		logic [1:0]  reg_idx;
		logic [31:0] value;
	} dir_row_t;

	// DUT ports
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// register shadows
	logic [15:0] cfg_line_len  = 16'd60;
	logic [16:0] cfg_first_brk = 17'h1FFFF;
	logic [23:0] cfg_blk_len   = 24'd0;

	// line state shadows
	logic [15:0] line_left = 16'd0;
	logic        brk_off   = 1'b1;
	logic [23:0] emit_cnt  = 24'd0;

	text_beat_t  text_due[$];
	logic [7:0]  item_txt[$];
	dir_row_t    dir_tab[$];
	text_beat_t  head_due;

	int n_items  = 0;
	int n_bytes  = 0;
	int n_errors = 0;
	int idle_cyc = 0;
	int rx_hold  = 0;
	bit no_gaps  = 1'b0;

	fasta_sequence_reassembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Refill the line budget from the line length; zero turns breaks off
	function automatic void reload_line();
		line_left = cfg_line_len;
		brk_off = (cfg_line_len == 16'd0);
	endfunction

	// Append one text byte, drop it past the per-item cap
	function automatic void put_text(input logic [7:0] ch);
		if (item_txt.size() >= TEXT_CAP)
			return;
		item_txt.push_back(ch);
		if (emit_cnt < COUNT_MAX)
			emit_cnt = emit_cnt + 24'd1;
	endfunction

	// Sequence letter: break the line first when the budget is spent
	function automatic void put_seq_letter(input logic [7:0] ch);
		if (!brk_off && line_left == 16'd0) begin
			put_text(CH_NL);
			reload_line();
		end
		put_text(ch);
		if (!brk_off && line_left != 16'd0)
			line_left = line_left - 16'd1;
	endfunction

	// Compute the text bytes one input beat produces
	function automatic void predict_text(input logic [2:0] cmd, input logic [7:0] data,
			input logic [4:0] run, input logic rlast);
		int k;
		int cnt;
		item_txt.delete();
		case (cmd)
			CMD_DNA: begin
				for (k = 0; k < 4; k++)
					put_seq_letter(BASE_CHARS[8 * data[2 * k +: 2] +: 8]);
			end
			CMD_LIT: begin
				put_seq_letter(data);
			end
			CMD_NRUN: begin
				cnt = (run > RUN_CAP) ? RUN_CAP : int'(run);
				for (k = 0; k < cnt; k++)
					put_seq_letter(CH_N);
			end
			CMD_RAW: begin
				put_text(data);
				if (rlast) begin
					put_text(CH_NL);
					reload_line();
				end
			end
			CMD_BSTART: begin
				emit_cnt = 24'd0;
				if (cfg_first_brk[16]) begin
					brk_off = 1'b1;
					line_left = 16'd0;
				end else begin
					brk_off = 1'b0;
					line_left = cfg_first_brk[15:0];
				end
			end
			CMD_BEND: begin
				if (emit_cnt < cfg_blk_len)
					put_text(CH_NL);
			end
			default: begin
			end
		endcase
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic dir_row_t item_row(input logic [2:0] cmd, input logic [7:0] data,
			input logic [4:0] run, input logic rlast, input logic typed,
			input logic [3:0] n_exp, input logic [63:0] exp_txt);
		dir_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.cmd = cmd;
		row.data = data;
		row.run = run;
		row.rlast = rlast;
		row.typed = typed;
		row.n_exp = n_exp;
		row.exp_txt = exp_txt;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.value = value;
		return row;
	endfunction

	// Present one input beat and hold it until accepted
	task automatic drive_item(input logic [2:0] cmd, input logic [7:0] data,
			input logic [4:0] run, input logic rlast, input logic typed = 1'b0,
			input logic [3:0] n_exp = '0, input logic [63:0] exp_txt = '0);
		int gap;
		int i;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		predict_text(cmd, data, run, rlast);
		if (typed) begin
			for (i = 0; i < n_exp; i++)
				text_due.push_back({exp_txt[8 * (n_exp - 1 - i) +: 8], i == n_exp - 1});
		end else begin
			for (i = 0; i < item_txt.size(); i++)
				text_due.push_back({item_txt[i], i == item_txt.size() - 1});
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, run, data};
		s_tlast <= rlast;
		do @(posedge clk); while (!s_tready);
		if (!(cmd == CMD_SPARE6 || cmd == CMD_SPARE7 || (cmd == CMD_NRUN && run == 5'd0)))
			n_items++;
	endtask

	// Stop sending and wait until every expected byte has come out
	task automatic drain_all();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (text_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LINE_LENGTH: cfg_line_len = value[15:0];
			REG_FIRST_BREAK: cfg_first_brk = value[16:0];
			REG_BLK_LEN: cfg_blk_len = value[23:0];
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] line_len, input logic [31:0] first_brk,
			input logic [31:0] blk_len);
		drain_all();
		apb_write(REG_LINE_LENGTH, line_len);
		apb_write(REG_FIRST_BREAK, first_brk);
		apb_write(REG_BLK_LEN, blk_len);
	endtask

	// One well-formed block: header run, sequence items, block end
	task automatic send_block();
		int nh;
		int ns;
		int nr;
		int i;
		int j;
		int r;
		logic [4:0] run;
		no_gaps = ($urandom_range(0, 3) == 0);
		drive_item(CMD_BSTART, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
			1'($urandom_range(0, 1)));
		nh = $urandom_range(1, 6);
		for (i = 0; i < nh; i++)
			drive_item(CMD_RAW, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				i == nh - 1);
		ns = $urandom_range(2, 14);
		for (i = 0; i < ns; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				drive_item(CMD_DNA, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			end else if (r < 75) begin
				run = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) :
					5'($urandom_range(1, 16));
				drive_item(CMD_NRUN, 8'($urandom_range(0, 255)), run,
					1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				drive_item(CMD_LIT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			end else begin
				nr = $urandom_range(1, 3);
				for (j = 0; j < nr; j++)
					drive_item(CMD_RAW, 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)), j == nr - 1);
			end
		end
		drive_item(CMD_BEND, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
			1'($urandom_range(0, 1)));
	endtask

	// Receiver: random stalls, mostly short, some long, some long ready stretches
	initial begin
		int r;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					m_tready <= 1'b1;
					rx_hold = $urandom_range(0, 8);
				end else if (r < 60) begin
					m_tready <= 1'b1;
					rx_hold = $urandom_range(20, 60);
				end else if (r < 93) begin
					m_tready <= 1'b0;
					rx_hold = $urandom_range(0, 2);
				end else begin
					m_tready <= 1'b0;
					rx_hold = $urandom_range(10, 40);
				end
			end
		end
	end

	// Compare each output beat with the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_bytes++;
			if (text_due.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected beat, expected none, actual char=%02h last=%0b",
						$time, m_tdata, m_tlast);
			end else begin
				head_due = text_due.pop_front();
				if (m_tdata !== head_due.ch) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: out_char mismatch, expected %02h, actual %02h",
							$time, head_due.ch, m_tdata);
				end
				if (m_tlast !== head_due.lst) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, head_due.lst, m_tlast);
				end
			end
		end
	end

	// Watchdog: count cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles, %0d bytes still expected",
				$time, STALL_LIMIT, text_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int p;
		int target;
		logic [2:0] cmd;
		// directed rows; typed rows carry their text, first byte highest
		dir_tab.push_back(item_row(CMD_DNA, 8'h00, 5'd0, 1'b0, 1'b1, 4'd4, 64'("AAAA")));
		dir_tab.push_back(item_row(CMD_DNA, 8'hFF, 5'd31, 1'b1, 1'b1, 4'd4, 64'("GGGG")));
		dir_tab.push_back(item_row(CMD_DNA, 8'hE4, 5'd0, 1'b0, 1'b1, 4'd4, 64'("ACTG")));
		dir_tab.push_back(item_row(CMD_LIT, 8'h00, 5'd0, 1'b0, 1'b1, 4'd1, 64'h00));
		dir_tab.push_back(item_row(CMD_LIT, 8'hFF, 5'd31, 1'b1, 1'b1, 4'd1, 64'hFF));
		dir_tab.push_back(item_row(CMD_NRUN, 8'h00, 5'd0, 1'b0, 1'b1, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_NRUN, 8'h00, 5'd1, 1'b0, 1'b1, 4'd1, 64'("N")));
		dir_tab.push_back(item_row(CMD_NRUN, 8'h00, 5'd16, 1'b0, 1'b0, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_NRUN, 8'hFF, 5'd31, 1'b1, 1'b0, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_SPARE6, 8'hFF, 5'd31, 1'b1, 1'b1, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_SPARE7, 8'h00, 5'd0, 1'b0, 1'b1, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_RAW, 8'h3E, 5'd0, 1'b0, 1'b1, 4'd1, 64'(">")));
		dir_tab.push_back(item_row(CMD_RAW, 8'h41, 5'd0, 1'b1, 1'b1, 4'd2, 64'("A\n")));
		dir_tab.push_back(item_row(CMD_DNA, 8'h00, 5'd0, 1'b0, 1'b0, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_BSTART, 8'h00, 5'd0, 1'b0, 1'b1, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_BEND, 8'h00, 5'd0, 1'b0, 1'b1, 4'd0, '0));
		// one letter per line from the first letter on, block length at its top
		dir_tab.push_back(cfg_row(REG_LINE_LENGTH, 32'd1));
		dir_tab.push_back(cfg_row(REG_FIRST_BREAK, 32'd0));
		dir_tab.push_back(cfg_row(REG_BLK_LEN, {8'h00, COUNT_MAX}));
		dir_tab.push_back(item_row(CMD_BSTART, 8'h00, 5'd0, 1'b0, 1'b1, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_NRUN, 8'h00, 5'd16, 1'b0, 1'b0, 4'd0, '0));
		dir_tab.push_back(item_row(CMD_LIT, 8'h61, 5'd0, 1'b0, 1'b1, 4'd2, 64'("\na")));
		dir_tab.push_back(item_row(CMD_BEND, 8'h00, 5'd0, 1'b0, 1'b1, 4'd1, 64'("\n")));
		// zero line length: the raw run end turns breaks off
		dir_tab.push_back(cfg_row(REG_LINE_LENGTH, 32'd0));
		dir_tab.push_back(item_row(CMD_RAW, 8'h78, 5'd0, 1'b1, 1'b1, 4'd2, 64'("x\n")));
		dir_tab.push_back(item_row(CMD_DNA, 8'h1B, 5'd0, 1'b0, 1'b1, 4'd4, 64'("GTCA")));
		dir_tab.push_back(item_row(CMD_NRUN, 8'h00, 5'd2, 1'b0, 1'b1, 4'd2, 64'("NN")));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				drain_all();
				apb_write(dir_tab[i].reg_idx, dir_tab[i].value);
			end else begin
				drive_item(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].run, dir_tab[i].rlast,
					dir_tab[i].typed, dir_tab[i].n_exp, dir_tab[i].exp_txt);
			end
		end

		// random phases, each under its own register setting
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_config(32'd4, 32'd2, 32'd50);
				1: set_config(32'd65535, 32'd65535, {8'h00, COUNT_MAX});
				2: set_config(32'd0, NO_BREAK, 32'd0);
				3: set_config(32'd1, 32'd0, 32'd120);
				4: set_config(32'd7, NO_BREAK, 32'd300);
				default: set_config($urandom_range(1, 20),
					($urandom_range(0, 3) == 0) ? NO_BREAK : $urandom_range(0, 10),
					$urandom_range(0, 300));
			endcase
			target = n_items + PHASE_ITEMS;
			while (n_items < target) begin
				if ($urandom_range(0, 99) < 75) begin
					send_block();
				end else begin
					no_gaps = 1'b0;
					cmd = 3'($urandom_range(0, 7));
					drive_item(cmd, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
						1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 9) == 0)
					drain_all();
			end
		end

		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d input items over %0d directed rows and %0d register settings,",
			n_items, dir_tab.size(), NUM_PHASES);
		$display("with %0d text beats compared and %0d mismatches.", n_bytes, n_errors);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/frsq_pkg.sv
hw/rtl/frsq_step.sv
hw/rtl/frsq_out.sv
hw/rtl/fasta_sequence_reassembler.sv
tb/fasta_sequence_reassembler_tb.sv
